>>> rtl/core/slt_pkg.sv
// Shared types and constants for the sorted list table.
package slt_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;
	localparam int MODE_W  = 2;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	typedef logic [MODE_W-1:0]         mode_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0]        count_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_ACT,
		ST_INS_SHIFT,
		ST_INS_WR,
		ST_REM_SHIFT,
		ST_DONE
	} state_t;

endpackage

>>> rtl/core/slt_in_if.sv
// Command channel interface: one operation word per handshake.
interface slt_in_if;
	import slt_pkg::*;

	logic   valid;
	logic   ready;
	mode_t  mode;
	value_t value;

	modport source(output valid, output mode, output value, input ready);
	modport sink(input valid, input mode, input value, output ready);
endinterface

>>> rtl/core/slt_out_if.sv
// Result channel interface: one result word per handshake.
interface slt_out_if;
	import slt_pkg::*;

	logic   valid;
	logic   ready;
	logic   ok;
	count_t count;

	modport source(output valid, output ok, output count, input ready);
	modport sink(input valid, input ok, input count, output ready);
endinterface

>>> rtl/core/slt_mem.sv
// Value store: one write port and one registered read port.
module slt_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  slt_pkg::value_t               wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output slt_pkg::value_t               rdata
);
	import slt_pkg::*;

	value_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> rtl/core/slt_ctrl.sv
// Sequencer that scans the store for the sorted position and shifts entries.
module slt_ctrl #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	slt_in_if.sink                            cmd,
	slt_out_if.source                         res,
	output logic                              mem_we,
	output logic [$clog2(CAPACITY)-1:0]       mem_waddr,
	output slt_pkg::value_t                   mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(CAPACITY)-1:0]       mem_raddr,
	input  slt_pkg::value_t                   mem_rdata
);
	import slt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t        state_q, state_d;
	mode_t         mode_q;
	value_t        value_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic          hit_q;
	logic          ok_q;
	logic          res_valid_q;
	logic          res_ok_q;
	count_t        res_count_q;

	logic [CW-1:0] idx_m1, idx_m2, idx_p1, idx_p2, pos_p1, cnt_m1;
	logic          full, empty, less, res_load;

	assign idx_m1   = idx_q - CW'(1);
	assign idx_m2   = idx_q - CW'(2);
	assign idx_p1   = idx_q + CW'(1);
	assign idx_p2   = idx_q + CW'(2);
	assign pos_p1   = pos_q + CW'(1);
	assign cnt_m1   = count_q - CW'(1);
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign less     = (mem_rdata < value_q);
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	assign res.valid = res_valid_q;
	assign res.ok    = res_ok_q;
	assign res.count = res_count_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				case (mode_q) inside
					MODE_INSERT: state_d = full ? ST_DONE : (empty ? ST_ACT : ST_SCAN);
					MODE_SEARCH, MODE_REMOVE: state_d = empty ? ST_ACT : ST_SCAN;
					default: state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				if (!less || idx_q == count_q) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				case (mode_q)
					MODE_INSERT: state_d = (pos_q == count_q) ? ST_INS_WR : ST_INS_SHIFT;
					MODE_REMOVE: begin
						if (!hit_q || pos_p1 == count_q) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_REM_SHIFT;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_INS_SHIFT: begin
				if (idx_m1 == pos_q) begin
					state_d = ST_INS_WR;
				end
			end
			ST_INS_WR: state_d = ST_DONE;
			ST_REM_SHIFT: begin
				if (idx_p2 == count_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_START: begin
				mem_re = !empty && !(mode_q == MODE_INSERT && full);
			end
			ST_SCAN: begin
				mem_re    = less && (idx_q != count_q);
				mem_raddr = idx_q[AW-1:0];
			end
			ST_ACT: begin
				if (mode_q == MODE_INSERT && pos_q != count_q) begin
					mem_re    = 1'b1;
					mem_raddr = cnt_m1[AW-1:0];
				end else if (mode_q == MODE_REMOVE && hit_q && pos_p1 != count_q) begin
					mem_re    = 1'b1;
					mem_raddr = pos_p1[AW-1:0];
				end
			end
			ST_INS_SHIFT: begin
				mem_we    = 1'b1;
				mem_re    = (idx_m1 != pos_q);
				mem_raddr = idx_m2[AW-1:0];
			end
			ST_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = value_q;
			end
			ST_REM_SHIFT: begin
				mem_we    = 1'b1;
				mem_re    = (idx_p2 != count_q);
				mem_raddr = idx_p2[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == ST_INS_WR) begin
				count_q <= count_q + CW'(1);
			end else if ((state_q == ST_ACT && mode_q == MODE_REMOVE && hit_q &&
			              pos_p1 == count_q) ||
			             (state_q == ST_REM_SHIFT && idx_p2 == count_q)) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mode_q  <= cmd.mode;
				value_q <= cmd.value;
			end
			ST_START: begin
				ok_q  <= 1'b0;
				idx_q <= CW'(1);
				pos_q <= '0;
				hit_q <= 1'b0;
			end
			ST_SCAN: begin
				if (less && idx_q == count_q) begin
					pos_q <= count_q;
					hit_q <= 1'b0;
				end else if (less) begin
					idx_q <= idx_p1;
				end else begin
					pos_q <= idx_m1;
					hit_q <= (mem_rdata == value_q);
				end
			end
			ST_ACT: begin
				case (mode_q)
					MODE_SEARCH: ok_q <= hit_q;
					MODE_INSERT: idx_q <= count_q;
					MODE_REMOVE: begin
						ok_q  <= hit_q;
						idx_q <= pos_q;
					end
					default: ok_q <= 1'b0;
				endcase
			end
			ST_INS_SHIFT: begin
				idx_q <= idx_m1;
			end
			ST_INS_WR: begin
				ok_q <= 1'b1;
			end
			ST_REM_SHIFT: begin
				idx_q <= idx_p1;
			end
			ST_DONE: begin
				if (res_load) begin
					res_ok_q    <= ok_q;
					res_count_q <= COUNT_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end
endmodule

>>> rtl/core/sorted_list_table.sv
// Top level of the sorted list table.
// The table holds up to CAPACITY signed 32-bit values in ascending order in a single
// synchronous memory. Each command word inserts, searches for or removes one value and
// returns one result word with a success flag and the count after the operation (the low
// seven bits of it). A command first scans the stored entries from the lowest, one entry
// per cycle, until it meets the first entry not below the value; an insert then shifts the
// entries above that point up by one and a remove shifts them down, again one entry per
// cycle through the one read port and the one write port. An insert into a full table is
// rejected without a scan, and on an empty table no scan is made. Commands are handled one
// at a time; the next command is taken as soon as the previous result is placed in the
// output register, even if that result has not yet been taken.
module sorted_list_table #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	slt_in_if.sink    cmd,
	slt_out_if.source res
);
	import slt_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	value_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	value_t        mem_rdata;

	slt_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	slt_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);
endmodule
